@@ hw/rtl/pba_pkg.sv @@
package pba_pkg;

    localparam int COUNT_W        = 16;
    localparam int ADDR_W         = 32;
    localparam int BYTES_W        = 32;
    localparam int INDEX_W        = 10;
    localparam int STATUS_W       = 2;
    localparam int S_DATA_W       = 80;
    localparam int M_DATA_W       = 16;
    localparam int DEF_PAGES      = 1024;
    localparam int DEF_PAGE_BYTES = 4096;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_NOFIT  = 2'd1,
        ST_UNUSED = 2'd2
    } status_t;

endpackage

@@ hw/rtl/pba_ram.sv @@
module pba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/page_block_allocator.sv @@
// First-fit page-block allocator with use counts. Each beat on the s_ side is one command:
// allocate (s_tuser = 0) rounds alloc_bytes up to pages of PAGE_BYTES and walks the block
// heads from entry 0, reusing a used block with the same address and length or taking the
// first free block that is long enough and splitting off the rest; release (s_tuser = 1)
// lowers the count of block_index and, at zero, clears its address and merges a free next
// block. Every command answers with exactly one m_ beat (result_index, status). An allocate
// first finds the page count (two multiply steps by a constant reciprocal and a remainder
// check), then reads the block memories once per block head visited, writes the split-off
// rest if it splits, and presents the result; a zero-size allocate answers without a walk;
// a release reads its head and, for a merge, the next block. After reset a clearing pass
// writes every table entry with s_tready low. A new command is taken while the previous result
// still waits on the m_ side; its result then waits until that beat has gone.
module page_block_allocator
    import pba_pkg::*;
#(
    parameter int PAGES      = DEF_PAGES,
    parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // alloc_bytes[31:0], phys_addr[63:32], block_index[73:64]
    input  logic                s_tuser,   // command
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // result_index[9:0], status[11:10]
);

    localparam int IW       = $clog2(PAGES);
    localparam int PW       = $clog2(PAGES + 1);
    localparam int CW       = PW + 1;
    localparam int A_W      = COUNT_W + ADDR_W;
    localparam int LOG_PB   = $clog2(PAGE_BYTES);
    localparam int QSH      = BYTES_W + LOG_PB;
    localparam int RCP_LO_W = 16;
    localparam int RCP_HI_W = BYTES_W + 1 - RCP_LO_W;
    localparam int PL_W     = BYTES_W + RCP_LO_W;
    localparam int PH_W     = BYTES_W + RCP_HI_W;
    localparam int PR_W     = PH_W + RCP_LO_W + 1;

    localparam logic [64:0]         RECIP    = ((65'(1) << QSH) / 65'(PAGE_BYTES)) + 65'(1);
    localparam logic [RCP_LO_W-1:0] RECIP_LO = RCP_LO_W'(RECIP);
    localparam logic [RCP_HI_W-1:0] RECIP_HI = RCP_HI_W'(RECIP >> RCP_LO_W);
    localparam logic [RCP_HI_W-1:0] PB_K     = RCP_HI_W'(PAGE_BYTES);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MUL_LO, S_MUL_HI, S_REM, S_WALK_RD, S_WALK_CHK, S_SPLIT,
        S_REL_RD, S_REL_CHK, S_MRG_RD, S_MRG_CHK, S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [IW-1:0]        clr_reg, clr_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [BYTES_W-1:0]   bytes_reg, bytes_next;
    logic [BYTES_W-1:0]   q_reg, q_next;
    logic [PL_W-1:0]      plo_reg, plo_next;
    logic [BYTES_W-1:0]   need_reg, need_next;
    logic [IW-1:0]        cur_reg, cur_next;
    logic [IW-1:0]        rd_reg, rd_next;
    logic [IW-1:0]        split_reg, split_next;
    logic [PW-1:0]        len_reg, len_next;
    logic [INDEX_W-1:0]   res_idx_reg, res_idx_next;
    status_t              res_st_reg, res_st_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [INDEX_W-1:0]   m_idx_reg, m_idx_next;
    status_t              m_st_reg, m_st_next;

    logic                 a_we, b_we;
    logic [IW-1:0]        a_waddr, b_waddr;
    logic [A_W-1:0]       a_wdata, a_rdata;
    logic [PW-1:0]        b_wdata, b_rdata;

    logic [BYTES_W-1:0]   s_bytes;
    logic [ADDR_W-1:0]    s_addr;
    logic [31:0]          s_idx32;
    logic [31:0]          cur32;
    logic [COUNT_W-1:0]   rd_cnt, cnt_inc, cnt_dec;
    logic [ADDR_W-1:0]    rd_addr;
    logic [BYTES_W-1:0]   len32;
    logic [CW-1:0]        nxt, split_at;
    logic [PH_W-1:0]      phi, qd;
    logic [PR_W-1:0]      prod, q_wide;

    pba_ram #(.WIDTH(A_W), .DEPTH(PAGES)) u_count_addr (
        .clk   (aclk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (rd_reg),
        .rdata (a_rdata)
    );

    pba_ram #(.WIDTH(PW), .DEPTH(PAGES)) u_pages (
        .clk   (aclk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (rd_reg),
        .rdata (b_rdata)
    );

    assign s_bytes  = s_tdata[BYTES_W-1:0];
    assign s_addr   = s_tdata[BYTES_W+ADDR_W-1:BYTES_W];
    assign s_idx32  = 32'(s_tdata[BYTES_W+ADDR_W+INDEX_W-1:BYTES_W+ADDR_W]);
    assign cur32    = 32'(cur_reg);

    assign rd_cnt   = a_rdata[A_W-1:ADDR_W];
    assign rd_addr  = a_rdata[ADDR_W-1:0];
    assign cnt_inc  = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + COUNT_W'(1);
    assign cnt_dec  = rd_cnt - COUNT_W'(1);
    assign len32    = BYTES_W'(b_rdata);
    assign nxt      = CW'(cur_reg) + CW'(b_rdata);
    assign split_at = CW'(cur_reg) + CW'(need_reg[PW-1:0]);

    // page count by reciprocal multiplication, exact for every 32-bit size
    assign phi      = PH_W'(bytes_reg) * PH_W'(RECIP_HI);
    assign prod     = PR_W'(plo_reg) + PR_W'({phi, RCP_LO_W'(0)});
    assign q_wide   = prod >> QSH;
    assign qd       = PH_W'(q_reg) * PH_W'(PB_K);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_DATA_W - INDEX_W - STATUS_W){1'b0}}, m_st_reg, m_idx_reg};

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        addr_next     = addr_reg;
        bytes_next    = bytes_reg;
        q_next        = q_reg;
        plo_next      = plo_reg;
        need_next     = need_reg;
        cur_next      = cur_reg;
        rd_next       = rd_reg;
        split_next    = split_reg;
        len_next      = len_reg;
        res_idx_next  = res_idx_reg;
        res_st_next   = res_st_reg;
        m_tvalid_next = m_tvalid_reg;
        m_idx_next    = m_idx_reg;
        m_st_next     = m_st_reg;
        a_we          = 1'b0;
        a_waddr       = cur_reg;
        a_wdata       = '0;
        b_we          = 1'b0;
        b_waddr       = cur_reg;
        b_wdata       = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                a_we    = 1'b1;
                a_waddr = clr_reg;
                a_wdata = (clr_reg == '0) ? {COUNT_W'(1), ADDR_W'(0)} : '0;
                b_we    = 1'b1;
                b_waddr = clr_reg;
                if (clr_reg == '0) begin
                    b_wdata = PW'(1);
                end else if (clr_reg == IW'(1)) begin
                    b_wdata = PW'(PAGES - 1);
                end
                clr_next = clr_reg + IW'(1);
                if (clr_reg == IW'(PAGES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    res_idx_next = '0;
                    addr_next    = s_addr;
                    bytes_next   = s_bytes;
                    if (!s_tuser) begin
                        if (s_bytes == '0) begin
                            res_st_next = ST_NOFIT;
                            state_next  = S_DONE;
                        end else begin
                            state_next = S_MUL_LO;
                        end
                    end else if (s_idx32 >= 32'(PAGES)) begin
                        res_st_next = ST_UNUSED;
                        state_next  = S_DONE;
                    end else begin
                        cur_next   = s_idx32[IW-1:0];
                        rd_next    = s_idx32[IW-1:0];
                        state_next = S_REL_RD;
                    end
                end
            end
            S_MUL_LO: begin
                plo_next   = PL_W'(bytes_reg) * PL_W'(RECIP_LO);
                state_next = S_MUL_HI;
            end
            S_MUL_HI: begin
                q_next     = q_wide[BYTES_W-1:0];
                state_next = S_REM;
            end
            S_REM: begin
                need_next  = q_reg + BYTES_W'(bytes_reg != qd[BYTES_W-1:0]);
                cur_next   = '0;
                rd_next    = '0;
                state_next = S_WALK_RD;
            end
            S_WALK_RD: begin
                state_next = S_WALK_CHK;
            end
            S_WALK_CHK: begin
                if (rd_cnt != '0 && rd_addr == addr_reg && len32 == need_reg) begin
                    a_we         = 1'b1;
                    a_wdata      = {cnt_inc, rd_addr};
                    res_idx_next = cur32[INDEX_W-1:0];
                    res_st_next  = ST_OK;
                    state_next   = S_DONE;
                end else if (rd_cnt == '0 && len32 >= need_reg) begin
                    a_we         = 1'b1;
                    a_wdata      = {COUNT_W'(1), addr_reg};
                    b_we         = 1'b1;
                    b_wdata      = need_reg[PW-1:0];
                    res_idx_next = cur32[INDEX_W-1:0];
                    res_st_next  = ST_OK;
                    len_next     = b_rdata;
                    split_next   = split_at[IW-1:0];
                    if (len32 > need_reg && split_at < CW'(PAGES)) begin
                        state_next = S_SPLIT;
                    end else begin
                        state_next = S_DONE;
                    end
                end else if (b_rdata == '0 || nxt >= CW'(PAGES - 1)) begin
                    res_idx_next = '0;
                    res_st_next  = ST_NOFIT;
                    state_next   = S_DONE;
                end else begin
                    cur_next   = nxt[IW-1:0];
                    rd_next    = nxt[IW-1:0];
                    state_next = S_WALK_RD;
                end
            end
            S_SPLIT: begin
                b_we       = 1'b1;
                b_waddr    = split_reg;
                b_wdata    = len_reg - need_reg[PW-1:0];
                state_next = S_DONE;
            end
            S_REL_RD: begin
                state_next = S_REL_CHK;
            end
            S_REL_CHK: begin
                if (rd_cnt == '0) begin
                    res_st_next = ST_UNUSED;
                    state_next  = S_DONE;
                end else begin
                    a_we        = 1'b1;
                    a_wdata     = {cnt_dec, (cnt_dec == '0) ? ADDR_W'(0) : rd_addr};
                    res_st_next = ST_OK;
                    len_next    = b_rdata;
                    if (cnt_dec == '0 && nxt < CW'(PAGES)) begin
                        rd_next    = nxt[IW-1:0];
                        state_next = S_MRG_RD;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_MRG_RD: begin
                state_next = S_MRG_CHK;
            end
            S_MRG_CHK: begin
                if (rd_cnt == '0) begin
                    b_we    = 1'b1;
                    b_wdata = len_reg + b_rdata;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_idx_next    = res_idx_reg;
                    m_st_next     = res_st_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        addr_reg    <= addr_next;
        bytes_reg   <= bytes_next;
        q_reg       <= q_next;
        plo_reg     <= plo_next;
        need_reg    <= need_next;
        cur_reg     <= cur_next;
        rd_reg      <= rd_next;
        split_reg   <= split_next;
        len_reg     <= len_next;
        res_idx_reg <= res_idx_next;
        res_st_reg  <= res_st_next;
        m_idx_reg   <= m_idx_next;
        m_st_reg    <= m_st_next;
    end

endmodule

@@ tb/alloc_cmd_pkg.sv @@
`timescale 1ns / 100ps
package alloc_cmd_pkg;

    typedef enum logic {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } alloc_cmd_t;

endpackage

@@ tb/page_alloc_checker.sv @@
`timescale 1ns / 100ps
module page_alloc_checker
    import pba_pkg::*;
    import alloc_cmd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    output int                  mismatches,
    output int                  awaiting
);

    localparam int PAGES      = DEF_PAGES;
    localparam int PAGE_BYTES = DEF_PAGE_BYTES;
    localparam int LEN_W      = $clog2(PAGES) + 1;
    localparam int HEAD_LSB   = BYTES_W + ADDR_W;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        status_t            status;
    } grant_t;

    logic [COUNT_W-1:0] use_cnt [PAGES];
    logic [LEN_W-1:0]   blk_len [PAGES];
    logic [ADDR_W-1:0]  blk_tag [PAGES];
    grant_t             expected_grants [$];

    // first-fit walk over the block heads, reuse or fresh grant as met first
    function automatic grant_t allocate_block(input logic [BYTES_W-1:0] bytes,
                                              input logic [ADDR_W-1:0] tag);
        grant_t      g;
        int unsigned need;
        int unsigned pos;
        int unsigned len;
        g.index  = '0;
        g.status = ST_NOFIT;
        need = bytes / PAGE_BYTES + (((bytes % PAGE_BYTES) != 0) ? 1 : 0);
        if (need == 0) begin
            return g;
        end
        pos = 0;
        while (pos < PAGES - 1) begin
            len = 32'(blk_len[pos]);
            if (use_cnt[pos] != 0) begin
                if (blk_tag[pos] == tag && len == need) begin
                    if (use_cnt[pos] != COUNT_MAX) begin
                        use_cnt[pos] = use_cnt[pos] + 1'b1;
                    end
                    g.index  = INDEX_W'(pos);
                    g.status = ST_OK;
                    return g;
                end
            end else if (len >= need) begin
                if (len > need && pos + need < PAGES) begin
                    blk_len[pos + need] = LEN_W'(len - need);
                end
                blk_len[pos] = LEN_W'(need);
                blk_tag[pos] = tag;
                use_cnt[pos] = COUNT_W'(1);
                g.index  = INDEX_W'(pos);
                g.status = ST_OK;
                return g;
            end
            if (len == 0) begin
                break;
            end
            pos += len;
        end
        return g;
    endfunction

    function automatic grant_t release_block(input logic [INDEX_W-1:0] head);
        grant_t      g;
        int unsigned len;
        int unsigned nxt;
        g.index  = '0;
        g.status = ST_OK;
        if (use_cnt[head] == 0) begin
            g.status = ST_UNUSED;
            return g;
        end
        use_cnt[head] = use_cnt[head] - 1'b1;
        if (use_cnt[head] == 0) begin
            len = 32'(blk_len[head]);
            blk_tag[head] = '0;
            nxt = head + len;
            if (nxt < PAGES && use_cnt[nxt] == 0) begin
                blk_len[head] = LEN_W'(len + blk_len[nxt]);
            end
        end
        return g;
    endfunction

    always @(posedge aclk) begin
        grant_t             want;
        logic [INDEX_W-1:0] got_index;
        status_t            got_status;
        if (!aresetn) begin
            foreach (use_cnt[k]) begin
                use_cnt[k] = '0;
                blk_len[k] = '0;
                blk_tag[k] = '0;
            end
            use_cnt[0] = COUNT_W'(1);
            blk_len[0] = LEN_W'(1);
            blk_len[1] = LEN_W'(PAGES - 1);
            expected_grants.delete();
            mismatches = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_index  = m_tdata[INDEX_W-1:0];
                got_status = status_t'(m_tdata[INDEX_W +: STATUS_W]);
                if (expected_grants.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result beat, index %0d status %0d",
                             $time, got_index, got_status);
                end else begin
                    want = expected_grants.pop_front();
                    if (got_index !== want.index) begin
                        mismatches++;
                        $display("%0t: result_index expected %0d actual %0d",
                                 $time, want.index, got_index);
                    end
                    if (got_status !== want.status) begin
                        mismatches++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got_status);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (alloc_cmd_t'(s_tuser) == CMD_RELEASE) begin
                    expected_grants.push_back(release_block(s_tdata[HEAD_LSB +: INDEX_W]));
                end else begin
                    expected_grants.push_back(allocate_block(s_tdata[0 +: BYTES_W],
                                                             s_tdata[BYTES_W +: ADDR_W]));
                end
            end
        end
        awaiting = expected_grants.size();
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
module tb;
    import pba_pkg::*;
    import alloc_cmd_pkg::*;

    localparam int PAGES        = DEF_PAGES;
    localparam int PAGE_BYTES   = DEF_PAGE_BYTES;
    localparam int RANDOM_ITEMS = 290;
    localparam int CYCLE_LIMIT  = 3_000_000;

    typedef struct {
        logic [BYTES_W-1:0] bytes;
        logic [ADDR_W-1:0]  tag;
    } alloc_req_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    int fail_count;
    int pending_count;
    int cycle_count = 0;
    int tx_idle_pct;
    int rx_idle_pct;

    logic [INDEX_W-1:0] live_heads [$];
    alloc_req_t         past_allocs [$];
    logic [ADDR_W-1:0]  tags [8];

    page_block_allocator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    page_alloc_checker alloc_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (fail_count),
        .awaiting   (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // granted heads, later picked for release
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready && m_tdata[INDEX_W +: STATUS_W] == ST_OK
                && m_tdata[INDEX_W-1:0] != 0) begin
            live_heads.push_back(m_tdata[INDEX_W-1:0]);
        end
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic send_beat(input alloc_cmd_t cmd, input logic [BYTES_W-1:0] bytes,
                             input logic [ADDR_W-1:0] tag, input logic [INDEX_W-1:0] head);
        @(negedge aclk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {{(S_DATA_W - BYTES_W - ADDR_W - INDEX_W){1'b0}}, head, tag, bytes};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic alloc_req(input logic [BYTES_W-1:0] bytes, input logic [ADDR_W-1:0] tag);
        send_beat(CMD_ALLOC, bytes, tag, INDEX_W'($urandom_range(0, PAGES - 1)));
    endtask

    task automatic release_req(input logic [INDEX_W-1:0] head);
        send_beat(CMD_RELEASE, $urandom, $urandom, head);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_count != 0) @(negedge aclk);
    endtask

    task automatic random_item();
        int         pick;
        int         slot;
        int         n_pages;
        alloc_req_t req;
        pick = $urandom_range(0, 99);
        if (pick >= 60 && pick < 88 && live_heads.size() != 0) begin
            slot = $urandom_range(0, live_heads.size() - 1);
            release_req(live_heads[slot]);
            live_heads.delete(slot);
        end else if (pick >= 88 && pick < 94) begin
            release_req(INDEX_W'($urandom_range(0, PAGES - 1)));
        end else if (pick >= 94) begin
            alloc_req(($urandom_range(0, 3) == 0) ? '0 : $urandom, $urandom);
        end else if (pick >= 45 && pick < 60 && past_allocs.size() != 0) begin
            req = past_allocs[$urandom_range(0, past_allocs.size() - 1)];
            alloc_req(req.bytes, req.tag);
        end else begin
            n_pages = ($urandom_range(0, 29) == 0) ? $urandom_range(100, 400)
                                                   : $urandom_range(1, 6);
            req.bytes = (n_pages - 1) * PAGE_BYTES + $urandom_range(1, PAGE_BYTES);
            req.tag   = tags[$urandom_range(0, 7)];
            past_allocs.push_back(req);
            alloc_req(req.bytes, req.tag);
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tuser     = CMD_ALLOC;
        s_tdata     = '0;
        tx_idle_pct = 26;
        rx_idle_pct = 85;
        foreach (tags[k]) tags[k] = $urandom;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        alloc_req('0, $urandom);
        alloc_req('1, '1);
        alloc_req(1, '0);
        alloc_req(PAGE_BYTES, 32'hA5A5_0000);
        alloc_req(PAGE_BYTES, 32'hA5A5_0000);
        alloc_req(PAGE_BYTES + 1, 32'h5A5A_FFFF);
        release_req(INDEX_W'(1));
        release_req(INDEX_W'(1));
        release_req(INDEX_W'(1));
        release_req('1);
        alloc_req(PAGE_BYTES, tags[0]);
        alloc_req((PAGES - 4) * PAGE_BYTES, tags[1]);
        alloc_req(PAGE_BYTES, tags[2]);
        release_req(INDEX_W'(4));
        release_req(INDEX_W'(2));
        release_req(INDEX_W'(0));
        release_req(INDEX_W'(0));
        release_req(INDEX_W'(0));
        alloc_req(PAGES * PAGE_BYTES, tags[3]);
        release_req(INDEX_W'(1));
        alloc_req((PAGES - 1) * PAGE_BYTES, tags[4]);
        release_req(INDEX_W'(1));
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                drain();
                tx_idle_pct = 85;
                rx_idle_pct = 26;
            end
            if (n == 2 * RANDOM_ITEMS / 3) begin
                drain();
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            random_item();
        end
        drain();
        repeat (40) @(posedge aclk);

        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
